/* src/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg - shared types and constants
// Item format between the classify front and the digit back, ASCII codes,
// and the power-of-ten table.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 6;
	localparam int POS_W   = 4;   // digit position 0..9
	localparam int WIDE_W  = 34;  // holds 9 * 10^9

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// one queued conversion: sign, magnitude, position of the leading digit
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [POS_W-1:0]   top_pos;
	} item_t;

	function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] p);
		logic [WIDE_W-1:0] r;
		unique case (p)
			4'd0:    r = 34'd1;
			4'd1:    r = 34'd10;
			4'd2:    r = 34'd100;
			4'd3:    r = 34'd1000;
			4'd4:    r = 34'd10000;
			4'd5:    r = 34'd100000;
			4'd6:    r = 34'd1000000;
			4'd7:    r = 34'd10000000;
			4'd8:    r = 34'd100000000;
			4'd9:    r = 34'd1000000000;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

endpackage

/* src/sitda_front.sv */
// ----------------------------------------------------------------------------
// sitda_front - input stage
// Takes the integer, forms sign and magnitude, then finds the leading digit
// position and hands the item to the queue.
// ----------------------------------------------------------------------------
module sitda_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sitda_pkg::VALUE_W-1:0] in_value,
	output logic                          push,
	input  logic                          push_ready,
	output sitda_pkg::item_t              push_item
);
	import sitda_pkg::*;

	logic               vld_s1;
	logic               neg_s1;
	logic [VALUE_W-1:0] mag_s1;
	logic [POS_W-1:0]   top_pos;

	assign in_ready = !vld_s1 || push_ready;
	assign push     = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// magnitude as unsigned: most negative value maps to 2^31 cleanly
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			neg_s1 <= in_value[VALUE_W-1];
			mag_s1 <= in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;
		end
	end

	// leading position = number of powers 10^1..10^9 not above the magnitude
	always_comb begin
		top_pos = '0;
		for (int i = 1; i <= 9; i++) begin
			top_pos = top_pos +
				POS_W'({2'b00, mag_s1} >= pow10(POS_W'(i)));
		end
	end

	assign push_item = '{neg: neg_s1, mag: mag_s1, top_pos: top_pos};

endmodule

/* src/sitda_queue.sv */
// ----------------------------------------------------------------------------
// sitda_queue - short item queue
// Register FIFO between front and back.
// ----------------------------------------------------------------------------
module sitda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  sitda_pkg::item_t push_item,
	output logic             pop_valid,
	input  logic             pop,
	output sitda_pkg::item_t pop_item
);
	import sitda_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

/* src/sitda_back.sv */
// ----------------------------------------------------------------------------
// sitda_back - character generator
// Emits a minus sign for a negative item, then one digit per cycle from the
// leading position down into an output register, unless the output stalls.
// ----------------------------------------------------------------------------
module sitda_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_pop,
	input  sitda_pkg::item_t             item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sitda_pkg::CHAR_W-1:0] out_char,
	output logic                         out_last
);
	import sitda_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SIGN  = 3'b010,
		ST_DIGIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] rem_q;
	logic [POS_W-1:0]   pos_q;
	logic               o_valid_q;
	logic [CHAR_W-1:0]  o_char_q;
	logic               o_last_q;

	logic               adv;
	logic [3:0]         digit;
	logic [WIDE_W-1:0]  sub;
	logic [WIDE_W-1:0]  unit;

	assign adv       = !o_valid_q || out_ready;
	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign out_valid = o_valid_q;
	assign out_char  = o_char_q;
	assign out_last  = o_last_q;

	// digit = largest k with k * 10^pos <= remainder
	always_comb begin
		unit  = pow10(pos_q);
		digit = '0;
		sub   = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({2'b00, rem_q} >= WIDE_W'(k) * unit) begin
				digit = 4'(k);
				sub   = WIDE_W'(k) * unit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (adv) begin
						o_valid_q <= 1'b0;
					end
					if (item_valid) begin
						state_q <= item.neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (adv) begin
						o_valid_q <= 1'b1;
						state_q   <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (adv) begin
						o_valid_q <= 1'b1;
						if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			rem_q <= item.mag;
			pos_q <= item.top_pos;
		end else if (state_q == ST_SIGN && adv) begin
			o_char_q <= CHAR_MINUS;
			o_last_q <= 1'b0;
		end else if (state_q == ST_DIGIT && adv) begin
			o_char_q <= CHAR_ZERO + CHAR_W'(digit);
			o_last_q <= (pos_q == '0);
			rem_q    <= rem_q - sub[VALUE_W-1:0];
			pos_q    <= pos_q - 1'b1;
		end
	end

endmodule

/* src/signed_int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit - signed 32-bit integer to decimal text
//
// Input stream s_axis: one transfer per integer, tdata[31:0] = value in two's
// complement. Output stream m_axis: one transfer per character, most
// significant first; tdata[5:0] = ASCII code ('-' or '0'..'9'), upper bits
// zero; tlast marks the final character. Zero gives "0", the most negative
// value gives "-2147483648"; no terminator is sent.
// The digit generator passes through its idle state for each integer, then
// emits one character per cycle unless the receiver stalls. Each integer
// passes the input stage register, the queue and the output register.
// The input stage and a two-entry queue keep accepting integers while the
// generator works or the receiver stalls; once they fill, s_axis_tready
// drops. A stalled output holds its character and tlast steady.
// Reset clears the queue, the stage valids and the output valid; no
// partial run survives reset.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
	output logic        m_axis_tlast    // is_last
);
	import sitda_pkg::*;

	logic              push;
	logic              push_ready;
	item_t             push_item;
	logic              pop_valid;
	logic              pop;
	item_t             pop_item;
	logic [CHAR_W-1:0] out_char;

	// front: sign/magnitude and leading-digit classification
	sitda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_value   (s_axis_tdata),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue
	sitda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	// back: sign and digit emission into the output register
	sitda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_pop   (pop),
		.item       (pop_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (out_char),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_char};

endmodule

/* tb/sv/decimal_text_monitor.sv */
// ----------------------------------------------------------------------------
// decimal_text_monitor - predicts and checks the decimal text stream
// Watches both streams of the integer-to-text unit, builds the expected
// characters for every accepted integer and compares each output transfer.
// ----------------------------------------------------------------------------
module decimal_text_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
	input  logic        m_axis_tlast,   // is_last
	output int          error_count,
	output int          chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sitda_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	text_char_t expected_chars[$];

	// sign first, then digits most significant first; last one flagged
	task automatic queue_decimal_text(input logic [VALUE_W-1:0] value);
		logic              neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0]        digit[10];
		int                ndig;
		text_char_t        c;
		neg  = value[VALUE_W-1];
		mag  = neg ? (~value + 1'b1) : value;
		ndig = 0;
		do begin
			digit[ndig] = 4'(mag % 10);
			mag         = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < 10);
		if (neg) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			c.code = CHAR_ZERO + CHAR_W'(digit[k]);
			c.last = (k == 0);
			expected_chars.push_back(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			error_count   = 0;
			chars_pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				queue_decimal_text(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== {2'b00, want.code}) begin
						$display("%0t: character mismatch: expected %h, actual %h",
							$time, {2'b00, want.code}, m_axis_tdata);
						error_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: tlast mismatch: expected %b, actual %b",
							$time, want.last, m_axis_tlast);
						error_count++;
					end
				end
			end
			chars_pending = expected_chars.size();
		end
	end

endmodule

/* tb/sv/signed_int_to_decimal_ascii_unit_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb - top of the integer-to-text bench
// Drives integers into the unit in random bursts, stalls the character
// stream on its own pattern, and lets decimal_text_monitor predict and
// compare every character. Directed corner values come first, then random
// values biased toward sign, digit-count and power-of-ten boundaries.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sitda_pkg::*;

	localparam int RANDOM_ITEMS = 80;
	localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;    // quiet tail after the last character

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [5:0] character, [7:6] zero
	logic        m_axis_tlast;   // is_last

	int error_count;
	int chars_pending;

	// handshake between stimulus and receiver for the one long hold-off
	logic hold_req;
	logic hold_done;

	signed_int_to_decimal_ascii_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	decimal_text_monitor text_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.error_count   (error_count),
		.chars_pending (chars_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop: far beyond the slowest legal run (a few hundred us)
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Offer one integer. Called at a falling edge; returns at the falling edge
	// after the transfer with tvalid still high, so a burst continues without
	// tvalid ever dropping in between.
	task automatic offer_value(input logic [31:0] v);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = v;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// idle the input for a number of cycles; zero keeps the burst going
	task automatic input_gap(input int cycles);
		if (cycles > 0) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = $urandom;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// hold input off until every predicted character has come out
	task automatic wait_drained();
		input_gap(1);
		while (chars_pending != 0) @(negedge clk);
	endtask

	// Receiver: runs of random length, each with its own stall pattern
	// (always ready, coin flip, mostly stalled, alternating). The one long
	// hold-off is counted here while the sender keeps offering.
	initial begin
		int mode;
		int run_len;
		m_axis_tready = 1'b0;
		hold_done     = 1'b0;
		forever begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(4, 40);
			repeat (run_len) begin
				@(negedge clk);
				if (hold_req && !hold_done) begin
					m_axis_tready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					2: m_axis_tready = ($urandom_range(0, 3) == 0);
					default: m_axis_tready = ~m_axis_tready;
				endcase
			end
		end
	end

	// Stimulus
	initial begin
		logic [31:0] directed[$];
		logic [31:0] v;
		logic [31:0] p10;
		int          sent;
		int          burst;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		hold_req      = 1'b0;
		arst_n        = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// corner values: zero, single digits, digit-count boundaries, both
		// extremes (most negative needs the unsigned magnitude), bit patterns
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
			32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'd1_000_000_000, 32'd999_999_999, -32'sd999_999_999,
			-32'sd1_000_000_000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1_234_567_890};
		foreach (directed[i]) begin
			offer_value(directed[i]);
			input_gap($urandom_range(0, 2));
		end
		wait_drained();

		// receiver holds off while a back-to-back burst piles up at the input
		hold_req = 1'b1;
		repeat (12) offer_value($urandom);
		input_gap(1);
		while (!hold_done) @(negedge clk);
		hold_req = 1'b0;

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// mostly short bursts, sometimes a long gapless stretch
			burst = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 8);
			repeat (burst) begin
				case ($urandom_range(0, 7))
					0, 1, 2: v = $urandom;
					3: v = $urandom_range(0, 99);
					4: begin
						// just around a power of ten
						p10 = 32'd1;
						repeat ($urandom_range(0, 9)) p10 = p10 * 10;
						v = p10 + $urandom_range(0, 2) - 1;
					end
					5: case ($urandom_range(0, 3))
						0: v = 32'h8000_0000;
						1: v = 32'h7FFF_FFFF;
						2: v = 32'd0;
						default: v = 32'hFFFF_FFFF;
					endcase
					default: v = $urandom >> $urandom_range(0, 31);
				endcase
				if ($urandom_range(0, 1))
					v = -v;
				offer_value(v);
				sent++;
			end
			if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + burst)
				wait_drained();
			else
				input_gap($urandom_range(0, 6));
		end

		input_gap(1);
		while (chars_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0 && chars_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
